// File: hdl/windowed_fan_alarm_controller_unit_assert.svh
// assertion macros for the windowed fan alarm controller
// used by the top level; needs a signal named clock and one named reset
`ifndef WINDOWED_FAN_ALARM_CONTROLLER_UNIT_ASSERT_SVH
`define WINDOWED_FAN_ALARM_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define WFAC_ASSERT_SAME(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("wfac assertion failed");

// next-cycle implication, off during reset
`define WFAC_ASSERT_NEXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error("wfac assertion failed");

`endif

// File: hdl/wfac_pkg.sv
// shared types and constants of the windowed fan alarm controller
// no dependencies
package wfac_pkg;

   localparam int TEMP_W   = 12;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int SECS_W   = 17;   // holds 31*3600 + 63*60 + 63

   localparam logic [SECS_W-1:0] SEC_PER_HOUR = 17'd3600;
   localparam logic [SECS_W-1:0] SEC_PER_MIN  = 17'd60;
   localparam logic signed [TEMP_W:0] ONE_DEGREE = 13'sd16;

   localparam logic signed [TEMP_W-1:0] THRESHOLD_RESET = 12'sd480;

   // input kinds
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_KEY    = 1'b1;

   // register indexes
   localparam logic [2:0] REG_THRESHOLD    = 3'd0;
   localparam logic [2:0] REG_START_HOUR   = 3'd1;
   localparam logic [2:0] REG_START_MINUTE = 3'd2;
   localparam logic [2:0] REG_END_HOUR     = 3'd3;
   localparam logic [2:0] REG_END_MINUTE   = 3'd4;

   typedef enum logic [1:0] {
      ALARM_IDLE     = 2'd0,
      ALARM_SOUNDING = 2'd1,
      ALARM_SILENCED = 2'd2
   } alarm_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] threshold;
      logic [HOUR_W-1:0]        open_hour;
      logic [MINUTE_W-1:0]      open_minute;
      logic [HOUR_W-1:0]        close_hour;
      logic [MINUTE_W-1:0]      close_minute;
   } cfg_type;

   typedef struct packed {
      logic      fan;
      alarm_type alarm;
      logic      monitor;
   } state_type;

endpackage

// File: hdl/wfac_decide.sv
// next-state logic for one beat: window check, threshold bands, silence key
// depends on wfac_pkg
module wfac_decide (
   input  wfac_pkg::cfg_type                  cfg,
   input  wfac_pkg::state_type                cur,
   input  logic                               cmd,
   input  logic signed [wfac_pkg::TEMP_W-1:0] sample_temp,
   input  logic [wfac_pkg::HOUR_W-1:0]        now_hour,
   input  logic [wfac_pkg::MINUTE_W-1:0]      now_minute,
   input  logic [wfac_pkg::SECOND_W-1:0]      now_second,
   output wfac_pkg::state_type                nxt
);

   logic [wfac_pkg::SECS_W-1:0]      now_secs;
   logic [wfac_pkg::SECS_W-1:0]      start_secs;
   logic [wfac_pkg::SECS_W-1:0]      end_secs;
   logic                             in_win;
   logic                             win_enabled;
   logic signed [wfac_pkg::TEMP_W:0] temp_x;
   logic signed [wfac_pkg::TEMP_W:0] thr_x;
   logic signed [wfac_pkg::TEMP_W:0] thr_low;

   // seconds of day, constant multipliers only
   assign now_secs   = wfac_pkg::SECS_W'(now_hour) * wfac_pkg::SEC_PER_HOUR
                     + wfac_pkg::SECS_W'(now_minute) * wfac_pkg::SEC_PER_MIN
                     + wfac_pkg::SECS_W'(now_second);
   assign start_secs = wfac_pkg::SECS_W'(cfg.open_hour) * wfac_pkg::SEC_PER_HOUR
                     + wfac_pkg::SECS_W'(cfg.open_minute) * wfac_pkg::SEC_PER_MIN;
   assign end_secs   = wfac_pkg::SECS_W'(cfg.close_hour) * wfac_pkg::SEC_PER_HOUR
                     + wfac_pkg::SECS_W'(cfg.close_minute) * wfac_pkg::SEC_PER_MIN;

   // inclusive window, wraps past midnight when end lies before start
   assign in_win = (end_secs < start_secs)
                 ? ((now_secs >= start_secs) || (now_secs <= end_secs))
                 : ((now_secs >= start_secs) && (now_secs <= end_secs));
   assign win_enabled = (cfg.open_hour != '0) || (cfg.close_hour != '0);

   // one extra bit so threshold minus one degree cannot wrap
   assign temp_x  = {sample_temp[wfac_pkg::TEMP_W-1], sample_temp};
   assign thr_x   = {cfg.threshold[wfac_pkg::TEMP_W-1], cfg.threshold};
   assign thr_low = thr_x - wfac_pkg::ONE_DEGREE;

   always_comb begin
      nxt = cur;
      if (cmd == wfac_pkg::CMD_KEY) begin
         // key only silences a sounding alarm
         case (cur.alarm)
            wfac_pkg::ALARM_SOUNDING: nxt.alarm = wfac_pkg::ALARM_SILENCED;
            default:                  nxt.alarm = cur.alarm;
         endcase
      end else begin
         if (win_enabled) begin
            nxt.monitor = in_win;
         end
         if (!nxt.monitor) begin
            nxt.fan   = 1'b0;
            nxt.alarm = wfac_pkg::ALARM_IDLE;
         end else if (temp_x < thr_low) begin
            nxt.fan   = 1'b0;
            nxt.alarm = wfac_pkg::ALARM_IDLE;
         end else if (temp_x >= thr_x) begin
            nxt.fan = 1'b1;
            if (cur.alarm == wfac_pkg::ALARM_IDLE) begin
               nxt.alarm = wfac_pkg::ALARM_SOUNDING;
            end
         end else begin
            nxt.fan   = 1'b1;
            nxt.alarm = wfac_pkg::ALARM_IDLE;
         end
      end
   end

endmodule

// File: hdl/windowed_fan_alarm_controller_unit.sv
// top level of the windowed fan alarm controller: stream ports, register file, output buffer
// depends on wfac_pkg, wfac_decide and windowed_fan_alarm_controller_unit_assert.svh
//
// Each request beat is either a temperature sample with its time of day or a
// silence key press, and yields exactly one response beat with fan, buzzer,
// alarm status and monitoring flag after that beat. The decision is made in
// the cycle a beat is accepted and lands in the result register, or in the
// skid register while the result register is full, so one beat per cycle is
// sustained while rsp_tready is high. The two-entry output buffer drops
// req_tready only when both entries are full. Window hours and minutes and
// the threshold must be set through the csr port while the block is idle,
// which the block does not enforce; both window hours at zero turns window
// evaluation off and the monitoring flag keeps its last value.
`include "windowed_fan_alarm_controller_unit_assert.svh"
module windowed_fan_alarm_controller_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample_temp[11:0], now_hour[16:12],
                                    // now_minute[22:17], now_second[28:23], zero[31:29]
   input  logic [0:0]  req_tuser,   // cmd[0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // fan_on[0], buzzer_on[1], alarm_status[3:2],
                                    // monitor_active[4], zero[7:5]
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   wfac_pkg::cfg_type   cfg_ff;
   wfac_pkg::state_type state_ff;
   wfac_pkg::state_type state_in;
   logic [4:0]          main_ff;
   logic [4:0]          skid_ff;
   logic                main_valid_ff;
   logic                skid_valid_ff;
   logic [4:0]          result_in;
   logic                push;
   logic                pop;
   logic                csr_write;
   logic [2:0]          csr_index;
   logic                key_at_idle;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold    <= wfac_pkg::THRESHOLD_RESET;
         cfg_ff.open_hour    <= '0;
         cfg_ff.open_minute  <= '0;
         cfg_ff.close_hour   <= '0;
         cfg_ff.close_minute <= '0;
      end else if (csr_write) begin
         case (csr_index)
            wfac_pkg::REG_THRESHOLD:
               cfg_ff.threshold <= $signed(csr_pwdata[wfac_pkg::TEMP_W-1:0]);
            wfac_pkg::REG_START_HOUR:
               cfg_ff.open_hour <= csr_pwdata[wfac_pkg::HOUR_W-1:0];
            wfac_pkg::REG_START_MINUTE:
               cfg_ff.open_minute <= csr_pwdata[wfac_pkg::MINUTE_W-1:0];
            wfac_pkg::REG_END_HOUR:
               cfg_ff.close_hour <= csr_pwdata[wfac_pkg::HOUR_W-1:0];
            wfac_pkg::REG_END_MINUTE:
               cfg_ff.close_minute <= csr_pwdata[wfac_pkg::MINUTE_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         wfac_pkg::REG_THRESHOLD:    csr_prdata = {20'd0, cfg_ff.threshold};
         wfac_pkg::REG_START_HOUR:   csr_prdata = {27'd0, cfg_ff.open_hour};
         wfac_pkg::REG_START_MINUTE: csr_prdata = {26'd0, cfg_ff.open_minute};
         wfac_pkg::REG_END_HOUR:     csr_prdata = {27'd0, cfg_ff.close_hour};
         wfac_pkg::REG_END_MINUTE:   csr_prdata = {26'd0, cfg_ff.close_minute};
         default:                    csr_prdata = '0;
      endcase
   end

   // decision for the beat at the request port
   wfac_decide u_decide (
      .cfg         (cfg_ff),
      .cur         (state_ff),
      .cmd         (req_tuser[0]),
      .sample_temp ($signed(req_tdata[11:0])),
      .now_hour    (req_tdata[16:12]),
      .now_minute  (req_tdata[22:17]),
      .now_second  (req_tdata[28:23]),
      .nxt         (state_in)
   );

   assign result_in = {state_in.monitor, state_in.alarm,
                       (state_in.alarm == wfac_pkg::ALARM_SOUNDING), state_in.fan};

   // handshakes
   assign req_tready = !skid_valid_ff;
   assign push       = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {3'd0, main_ff};

   // controller state advances on every accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.fan     <= 1'b0;
         state_ff.alarm   <= wfac_pkg::ALARM_IDLE;
         state_ff.monitor <= 1'b1;
      end else if (push) begin
         state_ff <= state_in;
      end
   end

   // two-entry output buffer, valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end
   end

   // two-entry output buffer, payload
   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            main_ff <= skid_ff;
         end else if (push) begin
            main_ff <= result_in;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_ff <= result_in;
         end else begin
            main_ff <= result_in;
         end
      end
   end

   // key press accepted while the alarm is idle
   assign key_at_idle = push && (req_tuser[0] == wfac_pkg::CMD_KEY)
                     && (state_ff.alarm == wfac_pkg::ALARM_IDLE);

   // checks
   `WFAC_ASSERT_SAME(a_skid_behind_main, skid_valid_ff, main_valid_ff)
   `WFAC_ASSERT_SAME(a_alarm_needs_fan, state_ff.alarm != wfac_pkg::ALARM_IDLE, state_ff.fan)
   `WFAC_ASSERT_NEXT(a_key_keeps_idle, key_at_idle, state_ff.alarm == wfac_pkg::ALARM_IDLE)

endmodule

// File: tb/fan_alarm_scoreboard_pkg.sv
// scoreboard for the windowed fan alarm controller testbench: predicts and checks result beats
// depends on wfac_pkg for field widths, register indexes and alarm codes
`timescale 1ns / 100ps
package fan_alarm_scoreboard_pkg;

   // result fields as packed in rsp_tdata[4:0], highest first
   typedef struct packed {
      logic                monitor;
      wfac_pkg::alarm_type status;
      logic                buzzer;
      logic                fan;
   } fan_alarm_result_type;

   class fan_alarm_scoreboard;
      // register copies
      logic signed [wfac_pkg::TEMP_W-1:0] threshold;
      logic [wfac_pkg::HOUR_W-1:0]        open_hour;
      logic [wfac_pkg::MINUTE_W-1:0]      open_minute;
      logic [wfac_pkg::HOUR_W-1:0]        close_hour;
      logic [wfac_pkg::MINUTE_W-1:0]      close_minute;
      // controller state
      logic                               fan;
      wfac_pkg::alarm_type                mode;
      logic                               monitor;
      fan_alarm_result_type               expected_q[$];
      int errors, checked, samples, keys, sounding_seen, silenced_seen, outside_seen;

      function new();
         threshold    = wfac_pkg::THRESHOLD_RESET;
         open_hour    = '0;
         open_minute  = '0;
         close_hour   = '0;
         close_minute = '0;
         fan          = 1'b0;
         mode         = wfac_pkg::ALARM_IDLE;
         monitor      = 1'b1;
         errors = 0; checked = 0; samples = 0; keys = 0;
         sounding_seen = 0; silenced_seen = 0; outside_seen = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            wfac_pkg::REG_THRESHOLD:    threshold    = value[wfac_pkg::TEMP_W-1:0];
            wfac_pkg::REG_START_HOUR:   open_hour    = value[wfac_pkg::HOUR_W-1:0];
            wfac_pkg::REG_START_MINUTE: open_minute  = value[wfac_pkg::MINUTE_W-1:0];
            wfac_pkg::REG_END_HOUR:     close_hour   = value[wfac_pkg::HOUR_W-1:0];
            wfac_pkg::REG_END_MINUTE:   close_minute = value[wfac_pkg::MINUTE_W-1:0];
            default: ;
         endcase
      endfunction

      // inclusive window, wraps past midnight when close lies before open
      function bit in_window(int unsigned now);
         int unsigned open_s, close_s;
         open_s  = int'(open_hour) * 3600 + int'(open_minute) * 60;
         close_s = int'(close_hour) * 3600 + int'(close_minute) * 60;
         if (close_s < open_s) return (now >= open_s) || (now <= close_s);
         return (now >= open_s) && (now <= close_s);
      endfunction

      // advance the state for one accepted request beat, queue the result
      function void note_input(logic cmd, logic [31:0] beat);
         int                   temp;
         int unsigned          now;
         fan_alarm_result_type r;
         if (cmd == wfac_pkg::CMD_KEY) begin
            keys++;
            if (mode == wfac_pkg::ALARM_SOUNDING) mode = wfac_pkg::ALARM_SILENCED;
         end else begin
            samples++;
            temp = $signed(beat[11:0]);
            now  = int'(beat[16:12]) * 3600 + int'(beat[22:17]) * 60 + int'(beat[28:23]);
            // window only evaluated when either hour is set
            if (open_hour != 0 || close_hour != 0) monitor = in_window(now);
            if (!monitor) begin
               fan  = 1'b0;
               mode = wfac_pkg::ALARM_IDLE;
            end else if (temp < int'(threshold) - int'(wfac_pkg::ONE_DEGREE)) begin
               fan  = 1'b0;
               mode = wfac_pkg::ALARM_IDLE;
            end else if (temp >= int'(threshold)) begin
               fan = 1'b1;
               if (mode == wfac_pkg::ALARM_IDLE) mode = wfac_pkg::ALARM_SOUNDING;
            end else begin
               fan  = 1'b1;
               mode = wfac_pkg::ALARM_IDLE;
            end
         end
         r.fan     = fan;
         r.buzzer  = (mode == wfac_pkg::ALARM_SOUNDING);
         r.status  = mode;
         r.monitor = monitor;
         expected_q.push_back(r);
      endfunction

      // compare one accepted result beat with the oldest prediction
      function void check_result(logic [7:0] beat);
         fan_alarm_result_type got, want;
         got = beat[4:0];
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result beat with nothing expected, actual %h", $time, beat);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (want.status == wfac_pkg::ALARM_SOUNDING) sounding_seen++;
         if (want.status == wfac_pkg::ALARM_SILENCED) silenced_seen++;
         if (!want.monitor) outside_seen++;
         if (got.fan !== want.fan || got.buzzer !== want.buzzer ||
             got.status !== want.status || got.monitor !== want.monitor) begin
            errors++;
            $display("%0t: mismatch exp/act fan %b/%b buzzer %b/%b status %0d/%0d monitor %b/%b",
                     $time, want.fan, got.fan, want.buzzer, got.buzzer,
                     want.status, got.status, want.monitor, got.monitor);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

endpackage

// File: tb/windowed_fan_alarm_controller_unit_tb.sv
// testbench top for windowed_fan_alarm_controller_unit: drives samples, keys and registers
// depends on wfac_pkg, fan_alarm_scoreboard_pkg and the block under test
`timescale 1ns / 100ps
module windowed_fan_alarm_controller_unit_tb;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   fan_alarm_scoreboard_pkg::fan_alarm_scoreboard sb = new();
   int burst_left = 0;
   int settings_used = 0;

   windowed_fan_alarm_controller_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #(10_000_000);
      $display("** windowed_fan_alarm_controller_unit: FAILED **");
      $finish;
   end

   // tdata: temp[11:0], hour[16:12], minute[22:17], second[28:23]
   function automatic logic [31:0] pack_sample(int temp, int hour, int minute, int second);
      return {3'b000, 6'(second), 6'(minute), 5'(hour), 12'(temp)};
   endfunction

   // one request beat, with a random gap opening each burst
   task automatic send_beat(logic cmd, logic [31:0] beat);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= beat;
      do @(posedge clock); while (!req_tready);
      sb.note_input(cmd, beat);
      burst_left--;
   endtask

   // setup then access; psel is left high for a following write
   task automatic write_csr(logic [2:0] idx, int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
   endtask

   task automatic set_window(int thr, int sh, int sm, int eh, int em);
      write_csr(wfac_pkg::REG_THRESHOLD, thr);
      write_csr(wfac_pkg::REG_START_HOUR, sh);
      write_csr(wfac_pkg::REG_START_MINUTE, sm);
      write_csr(wfac_pkg::REG_END_HOUR, eh);
      write_csr(wfac_pkg::REG_END_MINUTE, em);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      settings_used++;
   endtask

   // stop sending and let every expected result come back
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register setting for one random phase
   task automatic pick_setting(int kind);
      case (kind)
         0: set_window($urandom_range(0, 2880) - 880, 0, $urandom_range(0, 63),
                       0, $urandom_range(0, 63));
         1: set_window(2047, $urandom_range(12, 23), $urandom_range(0, 59),
                       $urandom_range(0, 11), $urandom_range(0, 59));
         2: set_window(-2048, $urandom_range(1, 10), $urandom_range(0, 59),
                       $urandom_range(11, 23), $urandom_range(0, 59));
         3: set_window($urandom_range(0, 2880) - 880, 9, 30, 9, 30);
         4: set_window($urandom_range(0, 4095), $urandom_range(24, 31), $urandom_range(60, 63),
                       $urandom_range(0, 31), $urandom_range(0, 63));
         5: set_window(480, 0, 0, 23, 59);
         7: set_window($urandom_range(0, 2880) - 880, $urandom_range(16, 23),
                       $urandom_range(0, 59), 0, $urandom_range(0, 59));
         default: set_window($urandom_range(0, 4095), $urandom_range(0, 31),
                             $urandom_range(0, 63), $urandom_range(0, 31),
                             $urandom_range(0, 63));
      endcase
   endtask

   // random sample, biased toward the threshold band and the window edges
   task automatic send_random_sample();
      int temp, h, m, s, sel;
      sel = $urandom_range(0, 99);
      if (sel < 60)      temp = int'(sb.threshold) + $urandom_range(0, 48) - 32;
      else if (sel < 85) temp = $urandom_range(0, 2880) - 880;
      else               temp = $urandom_range(0, 4095);
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
         if (sel < 25) begin
            h = sb.open_hour;
            m = sb.open_minute;
         end else begin
            h = sb.close_hour;
            m = sb.close_minute;
         end
         // one minute earlier half of the time
         if ($urandom_range(0, 1)) begin
            if (m == 0) begin
               m = 59;
               h = (h == 0) ? 23 : h - 1;
            end else begin
               m--;
            end
         end
         case ($urandom_range(0, 4))
            0: s = 0;
            1: s = 1;
            2: s = 59;
            3: s = 63;
            default: s = $urandom_range(0, 59);
         endcase
      end else if (sel < 85) begin
         h = $urandom_range(0, 23);
         m = $urandom_range(0, 59);
         s = $urandom_range(0, 59);
      end else begin
         h = $urandom_range(0, 31);
         m = $urandom_range(0, 63);
         s = $urandom_range(0, 63);
      end
      send_beat(wfac_pkg::CMD_SAMPLE, pack_sample(temp, h, m, s));
   endtask

   // response side: check accepted beats, stall on a pattern of its own
   initial begin
      int mode_left, stall_left, mode;
      mode_left  = 0;
      stall_left = 0;
      mode       = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 99) < 60);
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rsp_tready <= 1'b0;
               end else if ($urandom_range(0, 3) == 0) begin
                  stall_left = $urandom_range(1, 8);
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
         endcase
      end
   end

   // stimulus
   initial begin
      int order[8];
      order = '{5, 1, 0, 2, 3, 4, 7, 6};
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= wfac_pkg::CMD_SAMPLE;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: window off, threshold 30 degrees
      send_beat(wfac_pkg::CMD_SAMPLE, pack_sample(0, 12, 0, 0));
      send_beat(wfac_pkg::CMD_SAMPLE, pack_sample(464, 12, 0, 1));
      send_beat(wfac_pkg::CMD_SAMPLE, pack_sample(480, 12, 0, 2));
      send_beat(wfac_pkg::CMD_KEY, pack_sample(0, 0, 0, 0));
      send_beat(wfac_pkg::CMD_SAMPLE, pack_sample(2047, 12, 0, 3));
      send_beat(wfac_pkg::CMD_SAMPLE, pack_sample(470, 12, 0, 4));
      send_beat(wfac_pkg::CMD_KEY, pack_sample(-1, 31, 63, 63));
      send_beat(wfac_pkg::CMD_SAMPLE, pack_sample(500, 12, 0, 5));
      send_beat(wfac_pkg::CMD_SAMPLE, pack_sample(-2048, 12, 0, 6));
      send_beat(wfac_pkg::CMD_SAMPLE, pack_sample(463, 12, 0, 7));
      send_beat(wfac_pkg::CMD_SAMPLE, pack_sample(2047, 31, 63, 63));
      send_beat(wfac_pkg::CMD_KEY, pack_sample(0, 0, 0, 0));
      send_beat(wfac_pkg::CMD_KEY, pack_sample(0, 0, 0, 0));
      drain();

      // window wrapping past midnight, 22:30 to 06:15
      set_window(320, 22, 30, 6, 15);
      send_beat(wfac_pkg::CMD_SAMPLE, pack_sample(400, 22, 29, 59));
      send_beat(wfac_pkg::CMD_SAMPLE, pack_sample(400, 22, 30, 0));
      send_beat(wfac_pkg::CMD_KEY, pack_sample(0, 0, 0, 0));
      send_beat(wfac_pkg::CMD_SAMPLE, pack_sample(2000, 3, 0, 0));
      send_beat(wfac_pkg::CMD_SAMPLE, pack_sample(310, 6, 15, 0));
      send_beat(wfac_pkg::CMD_SAMPLE, pack_sample(400, 6, 15, 1));
      send_beat(wfac_pkg::CMD_SAMPLE, pack_sample(400, 12, 0, 0));
      drain();

      // both hours zero: monitoring keeps its last (off) value
      set_window(2047, 0, 63, 0, 63);
      send_beat(wfac_pkg::CMD_SAMPLE, pack_sample(2047, 10, 0, 0));
      send_beat(wfac_pkg::CMD_KEY, pack_sample(0, 0, 0, 0));
      drain();

      // random phases, one register setting each
      foreach (order[p]) begin
         pick_setting(order[p]);
         repeat (212) begin
            if ($urandom_range(0, 99) < 15)
               send_beat(wfac_pkg::CMD_KEY,
                         pack_sample($urandom_range(0, 4095), $urandom_range(0, 31),
                                     $urandom_range(0, 63), $urandom_range(0, 63)));
            else
               send_random_sample();
         end
         drain();
      end

      $display("covered %0d samples and %0d key presses over %0d register settings",
               sb.samples, sb.keys, settings_used);
      $display("results checked %0d: %0d sounding, %0d silenced, %0d outside the window",
               sb.checked, sb.sounding_seen, sb.silenced_seen, sb.outside_seen);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("** windowed_fan_alarm_controller_unit: PASSED **");
      else
         $display("** windowed_fan_alarm_controller_unit: FAILED **");
      $finish;
   end

endmodule
